// ----- hdl/dnsqs_pkg.sv -----
// Package for the DNS question sniffer: payload structs, status codes and
// fixed frame offsets. No dependencies.
package dnsqs_pkg;

  // Offsets into the frame for a 14-byte Ethernet and a 20-byte IPv4 header.
  localparam logic [15:0] POS_ETYPE_HI = 16'd12;
  localparam logic [15:0] POS_ETYPE_LO = 16'd13;
  localparam logic [15:0] POS_PROTO    = 16'd23;
  localparam logic [15:0] POS_SRC_LO   = 16'd26;
  localparam logic [15:0] POS_SRC_HI   = 16'd29;
  localparam logic [15:0] POS_DST_LO   = 16'd30;
  localparam logic [15:0] POS_DST_HI   = 16'd33;
  localparam logic [15:0] POS_ID_HI    = 16'd42;
  localparam logic [15:0] POS_ID_LO    = 16'd43;
  localparam logic [15:0] POS_FLAGS    = 16'd44;
  localparam logic [15:0] POS_QD_HI    = 16'd46;
  localparam logic [15:0] POS_QD_LO    = 16'd47;
  localparam logic [15:0] POS_REC_LO   = 16'd48;
  localparam logic [15:0] POS_REC_HI   = 16'd51;
  localparam logic [15:0] NAME_START   = 16'd54;
  localparam logic [15:0] POS_MAX      = 16'hFFFF;

  localparam logic [7:0] ETYPE_HI_IPV4 = 8'h08;
  localparam logic [7:0] ETYPE_LO_IPV4 = 8'h00;
  localparam logic [7:0] PROTO_UDP     = 8'd17;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_NOT_IPV4   = 3'd1,
    ST_NOT_UDP    = 3'd2,
    ST_QDCOUNT    = 3'd3,
    ST_QUERY_ANS  = 3'd4,
    ST_EMPTY_NAME = 3'd5,
    ST_TRUNC      = 3'd6
  } status_t;

  localparam logic KIND_NAME    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_end;
    logic [2:0] packet_kind;
  } in_item_t;

  typedef struct packed {
    logic        item_kind;
    logic [7:0]  name_char;
    status_t     status;
    logic [15:0] query_id;
    logic        is_response;
    logic [15:0] query_type;
    logic [7:0]  name_len;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [2:0]  packet_kind_out;
    logic        last_of_run;
  } out_item_t;

  // Everything one frame byte produces: an optional name byte, then an
  // optional summary.
  typedef struct packed {
    logic       has_name;
    logic [7:0] name_char;
    logic       has_sum;
    out_item_t  sum;
  } res_pair_t;

endpackage

// ----- hdl/dnsqs_parser.sv -----
// Per-byte frame parser: header checks, question name walk and summary.
// Depends on dnsqs_pkg.
module dnsqs_parser import dnsqs_pkg::*; #(
  parameter int unsigned MAX_NAME = 255
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_fire,
  input  in_item_t  in_item,
  output res_pair_t res,
  output logic      res_any
);

  logic [15:0] pos_r, pos_nxt;
  logic [7:0]  skip_r, skip_nxt;
  logic [7:0]  idx_r, idx_nxt;
  logic [7:0]  len_r, len_nxt;
  logic        done_r, done_nxt;
  status_t     st_r, st_nxt;
  logic [15:0] id_r, id_nxt;
  logic        resp_r, resp_nxt;
  logic        rec_r, rec_nxt;
  logic [31:0] src_r, src_nxt;
  logic [31:0] dst_r, dst_nxt;
  logic [15:0] qt_r, qt_nxt;

  always_comb begin
    logic [7:0]  b;
    logic [15:0] q;
    logic [15:0] thr;
    logic [8:0]  idx_inc;
    logic        counted;

    b        = in_item.frame_byte;
    counted  = 1'b0;
    q        = NAME_START + {8'd0, len_r};
    thr      = 16'd0;
    idx_inc  = {1'b0, idx_r} + 9'd1;

    skip_nxt = skip_r;
    idx_nxt  = idx_r;
    len_nxt  = len_r;
    done_nxt = done_r;
    st_nxt   = st_r;
    id_nxt   = id_r;
    resp_nxt = resp_r;
    rec_nxt  = rec_r;
    src_nxt  = src_r;
    dst_nxt  = dst_r;
    qt_nxt   = qt_r;
    res      = '0;

    // Header checks; the first failure sticks.
    if (st_nxt == ST_OK && pos_r == POS_ETYPE_HI && b != ETYPE_HI_IPV4) st_nxt = ST_NOT_IPV4;
    if (st_nxt == ST_OK && pos_r == POS_ETYPE_LO && b != ETYPE_LO_IPV4) st_nxt = ST_NOT_IPV4;
    if (st_nxt == ST_OK && pos_r == POS_PROTO && b != PROTO_UDP) st_nxt = ST_NOT_UDP;
    if (pos_r >= POS_SRC_LO && pos_r <= POS_SRC_HI) src_nxt = {src_r[23:0], b};
    if (pos_r >= POS_DST_LO && pos_r <= POS_DST_HI) dst_nxt = {dst_r[23:0], b};
    if (pos_r == POS_ID_HI || pos_r == POS_ID_LO) id_nxt = {id_r[7:0], b};
    if (pos_r == POS_FLAGS) resp_nxt = b[7];
    if (st_nxt == ST_OK && pos_r == POS_QD_HI && b != 8'd0) st_nxt = ST_QDCOUNT;
    if (st_nxt == ST_OK && pos_r == POS_QD_LO && b != 8'd1) st_nxt = ST_QDCOUNT;
    if (pos_r >= POS_REC_LO && pos_r <= POS_REC_HI && b != 8'd0) rec_nxt = 1'b1;
    if (st_nxt == ST_OK && pos_r == POS_REC_HI && !resp_r && rec_nxt) st_nxt = ST_QUERY_ANS;

    // Question name walk, then the two QTYPE bytes after it.
    if (done_r) begin
      if (pos_r == q + 16'd1 || pos_r == q + 16'd2) qt_nxt = {qt_r[7:0], b};
    end else if (pos_r >= NAME_START) begin
      if (skip_r != 8'd0) begin
        skip_nxt = skip_r - 8'd1;
        counted  = 1'b1;
      end else if (b == 8'd0) begin
        done_nxt = 1'b1;
        len_nxt  = idx_r;
        if (st_nxt == ST_OK && idx_r == 8'd0) st_nxt = ST_EMPTY_NAME;
      end else begin
        skip_nxt = b;
        counted  = 1'b1;
      end
      if (counted) begin
        res.has_name  = (st_nxt == ST_OK);
        res.name_char = b;
        idx_nxt       = idx_inc[7:0];
        if (idx_inc >= 9'(MAX_NAME)) begin
          done_nxt = 1'b1;
          len_nxt  = 8'(MAX_NAME);
        end
      end
    end

    pos_nxt = (pos_r == POS_MAX) ? pos_r : pos_r + 16'd1;

    if (in_item.frame_end) begin
      thr = NAME_START + {8'd0, len_nxt} + 16'd2;
      if (st_nxt == ST_OK && !(done_nxt && pos_r >= thr)) st_nxt = ST_TRUNC;
      res.has_sum                 = 1'b1;
      res.sum.item_kind           = KIND_SUMMARY;
      res.sum.name_char           = 8'd0;
      res.sum.status              = st_nxt;
      res.sum.query_id            = id_nxt;
      res.sum.is_response         = resp_nxt;
      res.sum.query_type          = qt_nxt;
      res.sum.name_len            = done_nxt ? len_nxt : idx_nxt;
      res.sum.src_ip              = src_nxt;
      res.sum.dst_ip              = dst_nxt;
      res.sum.packet_kind_out     = in_item.packet_kind;
      res.sum.last_of_run         = 1'b1;
    end

    res_any = res.has_name || res.has_sum;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (in_fire && in_item.frame_end)) begin
      pos_r  <= '0;
      skip_r <= '0;
      idx_r  <= '0;
      len_r  <= '0;
      done_r <= 1'b0;
      st_r   <= ST_OK;
      id_r   <= '0;
      resp_r <= 1'b0;
      rec_r  <= 1'b0;
      src_r  <= '0;
      dst_r  <= '0;
      qt_r   <= '0;
    end else if (in_fire) begin
      pos_r  <= pos_nxt;
      skip_r <= skip_nxt;
      idx_r  <= idx_nxt;
      len_r  <= len_nxt;
      done_r <= done_nxt;
      st_r   <= st_nxt;
      id_r   <= id_nxt;
      resp_r <= resp_nxt;
      rec_r  <= rec_nxt;
      src_r  <= src_nxt;
      dst_r  <= dst_nxt;
      qt_r   <= qt_nxt;
    end
  end

endmodule

// ----- hdl/dns_query_sniffer_top.sv -----
// Top level of the DNS question sniffer: parser plus a two-entry result queue.
// Depends on dnsqs_pkg and dnsqs_parser.
//
//   channel  direction  handshake             payload
//   in_      input      in_valid / in_ready   in_item_t   (one frame byte)
//   out_     output     out_valid / out_ready out_item_t  (name byte or summary)
//
// One frame byte is taken per cycle while in_ready is high; its results are
// registered in the result queue. The parser state updates in the cycle of
// the transfer, so bytes stream back to back. A final byte that is also a name
// byte gives two results, name byte then summary, from one queue entry. in_ready
// drops only while both queue entries are held. Reset clears parser and queue.
module dns_query_sniffer_top import dnsqs_pkg::*; #(
  parameter int unsigned MAX_NAME = 255
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  localparam logic [1:0] QDEPTH = 2'd2;

  res_pair_t res;
  logic      res_any;
  logic      in_fire, push, pop, out_fire, split;

  res_pair_t q_r [2];
  logic      wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;
  logic      phase_r;
  res_pair_t head;

  dnsqs_parser #(.MAX_NAME(MAX_NAME)) u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_fire),
    .in_item (in_item),
    .res     (res),
    .res_any (res_any)
  );

  assign in_ready  = (count_r != QDEPTH);
  assign in_fire   = in_valid && in_ready;
  assign push      = in_fire && res_any;
  assign head      = q_r[rd_ptr_r];
  assign out_valid = (count_r != 2'd0);
  assign out_fire  = out_valid && out_ready;
  // The name byte of an entry that also holds a summary goes out first.
  assign split     = head.has_name && head.has_sum && !phase_r;
  assign pop       = out_fire && !split;

  always_comb begin
    out_item = head.sum;
    if (head.has_name && !phase_r) begin
      out_item           = '0;
      out_item.item_kind = KIND_NAME;
      out_item.name_char = head.name_char;
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wr_ptr_r] <= res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
      phase_r  <= 1'b0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop) rd_ptr_r <= ~rd_ptr_r;
      if (out_fire) phase_r <= split;
      if (push && !pop) count_r <= count_r + 2'd1;
      else if (pop && !push) count_r <= count_r - 2'd1;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QDEPTH)
    else $error("result queue overfilled");

  a_head_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (head.has_name || head.has_sum))
    else $error("queue entry holds no result");

  a_summary_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.item_kind == KIND_SUMMARY) |-> out_item.last_of_run)
    else $error("summary without end of frame mark");

  a_split_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && split) |=> (out_valid && out_item.item_kind == KIND_SUMMARY))
    else $error("summary lost after final name byte");

endmodule
